// File: design/fnds_pkg.sv
// shared types, constants and command/status structs for the divider solver
// no dependencies
package fnds_pkg;

	localparam int DVD_W = 58;
	localparam int DVS_W = 38;
	localparam int DIV_CNT_W = 6;

	localparam logic [32:0] VCO_LOW_HZ = 33'd2200000000;
	localparam logic [32:0] VCO_HIGH_HZ = 33'd4400000000;
	localparam logic [23:0] RESYNC_DEN = 24'd10237500;
	localparam logic [11:0] FRAC_HALF = 12'd2047;
	localparam logic [11:0] RESYNC_MAX = 12'd4095;
	localparam logic [10:0] R_END = 11'd1024;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_VCO_RANGE = 2'd1;
	localparam logic [1:0] ST_NO_R = 2'd2;

	localparam logic [3:0] CFG_REFERENCE = 4'd0;
	localparam logic [3:0] CFG_DBL_THRESH = 4'd1;
	localparam logic [3:0] CFG_PFD_MAX = 4'd2;
	localparam logic [3:0] CFG_BAND_MAX = 4'd3;
	localparam logic [3:0] CFG_INT_MIN = 4'd4;
	localparam logic [3:0] CFG_OUT_MIN = 4'd5;
	localparam logic [3:0] CFG_OUT_MAX = 4'd6;
	localparam logic [3:0] CFG_MODE = 4'd7;

	typedef struct packed {
		logic [27:0] reference_hz;
		logic [27:0] doubler_threshold_hz;
		logic [27:0] pfd_max_hz;
		logic [27:0] band_clock_max_hz;
		logic [15:0] int_minimum;
		logic [6:0]  out_div_minimum;
		logic [6:0]  out_div_maximum;
		logic [1:0]  mode_flags;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_DOUBLE, OP_PREP, OP_STEP, OP_FNUM,
		OP_INTFIX, OP_NF, OP_PROD, OP_PUBLISH
	} op_t;

	typedef enum logic [2:0] {
		DSEL_N, DSEL_F, DSEL_B, DSEL_A, DSEL_R
	} div_sel_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DOUBLE, S_PREP, S_SEARCH, S_N_DIV, S_N_WAIT, S_FNUM,
		S_F_DIV, S_F_WAIT, S_INTFIX, S_B_DIV, S_B_WAIT, S_NF, S_PROD,
		S_A_DIV, S_A_WAIT, S_R_DIV, S_R_WAIT, S_FINISH
	} state_t;

	typedef struct packed {
		op_t      op;
		logic     div_start;
		div_sel_t div_sel;
	} cmd_t;

	typedef struct packed {
		logic dbl_more;
		logic search_end;
		logic search_hit;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

// File: design/fnds_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on fnds_pkg
module fnds_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [fnds_pkg::DVD_W-1:0] dvd,
	input  logic [fnds_pkg::DVS_W-1:0] dvs,
	output logic                      done,
	output logic [fnds_pkg::DVD_W-1:0] quot,
	output logic [fnds_pkg::DVS_W-1:0] rem
);
	logic [fnds_pkg::DVD_W-1:0]     quot_q;
	logic [fnds_pkg::DVS_W-1:0]     rem_q;
	logic [fnds_pkg::DVS_W-1:0]     dvs_q;
	logic [fnds_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [fnds_pkg::DVS_W:0]       shifted;
	logic [fnds_pkg::DVS_W:0]       diff;
	logic                           ge;

	assign shifted = {rem_q, quot_q[fnds_pkg::DVD_W-1]};
	assign ge = shifted >= {1'b0, dvs_q};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= fnds_pkg::DIV_CNT_W'(fnds_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == fnds_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			quot_q <= {quot_q[fnds_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? diff[fnds_pkg::DVS_W-1:0] : shifted[fnds_pkg::DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem = rem_q;
endmodule

// File: design/fnds_datapath.sv
// datapath: vco doubling, R search accumulators, shared divider and result words
// depends on fnds_pkg and fnds_divider
module fnds_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  fnds_pkg::cfg_t    cfg,
	input  fnds_pkg::cmd_t    cmd,
	output fnds_pkg::stat_t   stat,
	input  logic [32:0]       target_hz,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [11:0]       frac_value,
	output logic [15:0]       int_value,
	output logic [11:0]       resync_clock_div,
	output logic [9:0]        ref_counter,
	output logic              ref_halve_enable,
	output logic              ref_double_enable,
	output logic [7:0]        band_select_div,
	output logic [6:0]        output_div,
	output logic [32:0]       actual_hz,
	output logic [1:0]        status
);
	logic [32:0] target_q, vco_q;
	logic [28:0] refd_q;
	logic        dbl_q;
	logic [7:0]  rfdiv_q;
	logic [10:0] r_q;
	logic [37:0] p_q, b_q;
	logic [42:0] f_q;
	logic [45:0] b255_q;
	logic [44:0] thr_q;
	logic        nogo_q, found_q;
	logic [15:0] n_q;
	logic [28:0] rem_q;
	logic [42:0] fnum_q;
	logic [11:0] frac_q;
	logic [7:0]  bs_q;
	logic [27:0] nf_q;
	logic [56:0] prod_q;
	logic [21:0] den1_q;
	logic [29:0] den_q;
	logic [33:0] rsd_q;
	logic [32:0] act_q;
	logic [11:0] resync_q;
	fnds_pkg::div_sel_t sel_q;
	logic        out_valid_q;

	logic [28:0] refd_new;
	logic        dbl_new;
	logic [35:0] bmax255;
	logic [32:0] fb;
	logic        hit;
	logic [fnds_pkg::DVD_W-1:0] dvd;
	logic [fnds_pkg::DVS_W-1:0] dvs;
	logic        div_done;
	logic [fnds_pkg::DVD_W-1:0] quot;
	logic [fnds_pkg::DVS_W-1:0] drem;
	logic [7:0]  comp;
	logic        publish;

	assign dbl_new = cfg.reference_hz <= cfg.doubler_threshold_hz;
	assign refd_new = dbl_new ? {cfg.reference_hz, 1'b0} : {1'b0, cfg.reference_hz};
	assign bmax255 = {cfg.band_clock_max_hz, 8'b0} - 36'(cfg.band_clock_max_hz);
	assign fb = cfg.mode_flags[0] ? target_q : vco_q;
	assign comp = cfg.mode_flags[0] ? 8'd1 : rfdiv_q;

	assign hit = ({9'b0, refd_q} <= p_q) && ({2'b0, f_q} >= thr_q)
		&& ({2'b0, f_q} < {refd_q, 16'b0}) && ({17'b0, refd_q} <= b255_q);

	assign stat.dbl_more = (vco_q < fnds_pkg::VCO_LOW_HZ)
		&& (rfdiv_q < {1'b0, cfg.out_div_maximum});
	assign stat.search_end = nogo_q || (r_q == fnds_pkg::R_END);
	assign stat.search_hit = hit;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.div_sel)
			fnds_pkg::DSEL_N: begin
				dvd = {15'b0, f_q};
				dvs = {9'b0, refd_q};
			end
			fnds_pkg::DSEL_F: begin
				dvd = {15'b0, fnum_q};
				dvs = {8'b0, refd_q, 1'b0};
			end
			fnds_pkg::DSEL_B: begin
				dvd = {20'b0, b_q} + {29'b0, refd_q} - 58'd1;
				dvs = b_q;
			end
			fnds_pkg::DSEL_A: begin
				dvd = {1'b0, prod_q};
				dvs = {8'b0, den_q};
			end
			fnds_pkg::DSEL_R: begin
				dvd = {24'b0, rsd_q} + {29'b0, refd_q} - 58'd1;
				dvs = {4'b0, rsd_q};
			end
			default: begin
				dvd = '0;
				dvs = '0;
			end
		endcase
	end

	fnds_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.dvd   (dvd),
		.dvs   (dvs),
		.done  (div_done),
		.quot  (quot),
		.rem   (drem)
	);

	assign publish = (cmd.op == fnds_pkg::OP_PUBLISH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			sel_q <= cmd.div_sel;
		if (div_done) begin
			case (sel_q)
				fnds_pkg::DSEL_N: begin
					n_q <= quot[15:0];
					rem_q <= drem[28:0];
				end
				fnds_pkg::DSEL_F: frac_q <= quot[11:0];
				fnds_pkg::DSEL_B: bs_q <= quot[7:0];
				fnds_pkg::DSEL_A: act_q <= quot[32:0];
				fnds_pkg::DSEL_R: begin
					if (quot > fnds_pkg::DVD_W'(fnds_pkg::RESYNC_MAX))
						resync_q <= fnds_pkg::RESYNC_MAX;
					else if (quot == '0)
						resync_q <= 12'd1;
					else
						resync_q <= quot[11:0];
				end
				default: ;
			endcase
		end
		case (cmd.op)
			fnds_pkg::OP_LOAD: begin
				target_q <= target_hz;
				vco_q <= target_hz;
				dbl_q <= dbl_new;
				refd_q <= refd_new;
				rfdiv_q <= (cfg.out_div_minimum == '0) ? 8'd1 : {1'b0, cfg.out_div_minimum};
			end
			fnds_pkg::OP_DOUBLE: begin
				vco_q <= {vco_q[31:0], 1'b0};
				rfdiv_q <= {rfdiv_q[6:0], 1'b0};
			end
			fnds_pkg::OP_PREP: begin
				r_q <= 11'd1;
				p_q <= 38'(cfg.pfd_max_hz);
				f_q <= 43'(fb);
				b_q <= 38'(cfg.band_clock_max_hz);
				b255_q <= 46'(bmax255);
				thr_q <= 45'(cfg.int_minimum) * 45'(refd_q);
				nogo_q <= (refd_q == '0) || (cfg.band_clock_max_hz == '0);
				found_q <= 1'b0;
			end
			fnds_pkg::OP_STEP: begin
				if (!stat.search_end) begin
					if (hit) begin
						found_q <= 1'b1;
					end else begin
						r_q <= r_q + 11'd1;
						p_q <= p_q + 38'(cfg.pfd_max_hz);
						f_q <= f_q + 43'(fb);
						b_q <= b_q + 38'(cfg.band_clock_max_hz);
						b255_q <= b255_q + 46'(bmax255);
					end
				end
			end
			fnds_pkg::OP_FNUM: begin
				fnum_q <= 43'({rem_q, 13'b0}) - 43'({rem_q, 1'b0}) + 43'(refd_q);
			end
			fnds_pkg::OP_INTFIX: begin
				if (cfg.mode_flags[1]) begin
					if (frac_q > fnds_pkg::FRAC_HALF && n_q != 16'hFFFF)
						n_q <= n_q + 16'd1;
					frac_q <= '0;
				end
			end
			fnds_pkg::OP_NF: begin
				nf_q <= 28'({n_q, 12'b0}) - 28'(n_q) + 28'(frac_q);
				den1_q <= 22'({r_q[9:0], 12'b0}) - 22'(r_q[9:0]);
				rsd_q <= 34'(r_q[9:0]) * 34'(fnds_pkg::RESYNC_DEN);
			end
			fnds_pkg::OP_PROD: begin
				prod_q <= 57'(nf_q) * 57'(refd_q);
				den_q <= 30'(den1_q) * 30'(comp);
			end
			fnds_pkg::OP_PUBLISH: begin
				if (found_q) begin
					frac_value <= frac_q;
					int_value <= n_q;
					resync_clock_div <= resync_q;
					ref_counter <= r_q[0] ? r_q[9:0] : r_q[10:1];
					ref_halve_enable <= ~r_q[0];
					ref_double_enable <= dbl_q;
					band_select_div <= bs_q;
					output_div <= rfdiv_q[6:0];
					actual_hz <= act_q;
					status <= (vco_q < fnds_pkg::VCO_LOW_HZ || vco_q > fnds_pkg::VCO_HIGH_HZ)
						? fnds_pkg::ST_VCO_RANGE : fnds_pkg::ST_OK;
				end else begin
					frac_value <= '0;
					int_value <= '0;
					resync_clock_div <= '0;
					ref_counter <= '0;
					ref_halve_enable <= 1'b0;
					ref_double_enable <= 1'b0;
					band_select_div <= '0;
					output_div <= '0;
					actual_hz <= '0;
					status <= fnds_pkg::ST_NO_R;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

// File: design/fnds_ctrl.sv
// controller: sequences load, doubling, R search, divisions and result hand-off
// depends on fnds_pkg
module fnds_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  fnds_pkg::stat_t stat,
	output fnds_pkg::cmd_t  cmd
);
	fnds_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fnds_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd.op = fnds_pkg::OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel = fnds_pkg::DSEL_N;
		in_ready = 1'b0;
		case (state_q)
			fnds_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = fnds_pkg::OP_LOAD;
					state_d = fnds_pkg::S_DOUBLE;
				end
			end
			fnds_pkg::S_DOUBLE: begin
				if (stat.dbl_more)
					cmd.op = fnds_pkg::OP_DOUBLE;
				else
					state_d = fnds_pkg::S_PREP;
			end
			fnds_pkg::S_PREP: begin
				cmd.op = fnds_pkg::OP_PREP;
				state_d = fnds_pkg::S_SEARCH;
			end
			fnds_pkg::S_SEARCH: begin
				cmd.op = fnds_pkg::OP_STEP;
				if (stat.search_end)
					state_d = fnds_pkg::S_FINISH;
				else if (stat.search_hit)
					state_d = fnds_pkg::S_N_DIV;
			end
			fnds_pkg::S_N_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = fnds_pkg::DSEL_N;
				state_d = fnds_pkg::S_N_WAIT;
			end
			fnds_pkg::S_N_WAIT: if (stat.div_done) state_d = fnds_pkg::S_FNUM;
			fnds_pkg::S_FNUM: begin
				cmd.op = fnds_pkg::OP_FNUM;
				state_d = fnds_pkg::S_F_DIV;
			end
			fnds_pkg::S_F_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = fnds_pkg::DSEL_F;
				state_d = fnds_pkg::S_F_WAIT;
			end
			fnds_pkg::S_F_WAIT: if (stat.div_done) state_d = fnds_pkg::S_INTFIX;
			fnds_pkg::S_INTFIX: begin
				cmd.op = fnds_pkg::OP_INTFIX;
				state_d = fnds_pkg::S_B_DIV;
			end
			fnds_pkg::S_B_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = fnds_pkg::DSEL_B;
				state_d = fnds_pkg::S_B_WAIT;
			end
			fnds_pkg::S_B_WAIT: if (stat.div_done) state_d = fnds_pkg::S_NF;
			fnds_pkg::S_NF: begin
				cmd.op = fnds_pkg::OP_NF;
				state_d = fnds_pkg::S_PROD;
			end
			fnds_pkg::S_PROD: begin
				cmd.op = fnds_pkg::OP_PROD;
				state_d = fnds_pkg::S_A_DIV;
			end
			fnds_pkg::S_A_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = fnds_pkg::DSEL_A;
				state_d = fnds_pkg::S_A_WAIT;
			end
			fnds_pkg::S_A_WAIT: if (stat.div_done) state_d = fnds_pkg::S_R_DIV;
			fnds_pkg::S_R_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = fnds_pkg::DSEL_R;
				state_d = fnds_pkg::S_R_WAIT;
			end
			fnds_pkg::S_R_WAIT: if (stat.div_done) state_d = fnds_pkg::S_FINISH;
			fnds_pkg::S_FINISH: begin
				if (stat.out_free) begin
					cmd.op = fnds_pkg::OP_PUBLISH;
					state_d = fnds_pkg::S_IDLE;
				end
			end
			default: state_d = fnds_pkg::S_IDLE;
		endcase
	end
endmodule

// File: design/fractional_n_divider_solver.sv
// Divider solver top level: one target frequency word in, one divider setting word out.
// A request first runs the R search, one R per cycle (up to 1023); if an R is found, five
// divisions then run one after another on a shared one-bit-per-cycle divider.
// A finished word waits in the output register while the next request is taken.
// depends on fnds_pkg, fnds_ctrl and fnds_datapath
module fractional_n_divider_solver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [27:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [32:0] target_hz,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] frac_value,
	output logic [15:0] int_value,
	output logic [11:0] resync_clock_div,
	output logic [9:0]  ref_counter,
	output logic        ref_halve_enable,
	output logic        ref_double_enable,
	output logic [7:0]  band_select_div,
	output logic [6:0]  output_div,
	output logic [32:0] actual_hz,
	output logic [1:0]  status
);
	fnds_pkg::cfg_t  cfg_q;
	fnds_pkg::cmd_t  cmd;
	fnds_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reference_hz <= 28'd10000000;
			cfg_q.doubler_threshold_hz <= 28'd12500000;
			cfg_q.pfd_max_hz <= 28'd25000000;
			cfg_q.band_clock_max_hz <= 28'd100000;
			cfg_q.int_minimum <= 16'd23;
			cfg_q.out_div_minimum <= 7'd1;
			cfg_q.out_div_maximum <= 7'd64;
			cfg_q.mode_flags <= 2'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				fnds_pkg::CFG_REFERENCE: cfg_q.reference_hz <= cfg_data;
				fnds_pkg::CFG_DBL_THRESH: cfg_q.doubler_threshold_hz <= cfg_data;
				fnds_pkg::CFG_PFD_MAX: cfg_q.pfd_max_hz <= cfg_data;
				fnds_pkg::CFG_BAND_MAX: cfg_q.band_clock_max_hz <= cfg_data;
				fnds_pkg::CFG_INT_MIN: cfg_q.int_minimum <= cfg_data[15:0];
				fnds_pkg::CFG_OUT_MIN: cfg_q.out_div_minimum <= cfg_data[6:0];
				fnds_pkg::CFG_OUT_MAX: cfg_q.out_div_maximum <= cfg_data[6:0];
				fnds_pkg::CFG_MODE: cfg_q.mode_flags <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	fnds_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	fnds_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.cmd              (cmd),
		.stat             (stat),
		.target_hz        (target_hz),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.frac_value       (frac_value),
		.int_value        (int_value),
		.resync_clock_div (resync_clock_div),
		.ref_counter      (ref_counter),
		.ref_halve_enable (ref_halve_enable),
		.ref_double_enable(ref_double_enable),
		.band_select_div  (band_select_div),
		.output_div       (output_div),
		.actual_hz        (actual_hz),
		.status           (status)
	);
endmodule
